### hw/rtl/dit_pkg.sv
// Shared types and constants for the 4x4 dequant / inverse DCT / reconstruct block.
package dit_pkg;

  localparam int unsigned CoefW  = 16;
  localparam int unsigned PixW   = 8;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned BlkN   = 16;
  // butterfly internal width, covers a + d with headroom
  localparam int unsigned AccW   = 20;
  // constant products: 16-bit signed times 18-bit signed
  localparam int unsigned ProdW  = 34;
  localparam int unsigned MulW   = 18;

  localparam logic signed [MulW-1:0] COS_TERM = 18'sd20091;
  localparam logic signed [MulW-1:0] SIN_TERM = 18'sd35468;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COL_MUL,
    ST_COL_SUM,
    ST_ROW_MUL,
    ST_ROW_SUM,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/dequant_idct4x4_reconstruct_core.sv
// Top level: 4x4 dequantize, two-pass inverse DCT, add prediction and clamp.
// Flow: a block is loaded one item per cycle while in_valid holds (dequant multiply on
// entry), then 8 passes of the shared butterfly run, each a multiply and a sum state
// (DC-only skips them); then one pixel per cycle while out_ready holds.
// No new block is accepted until the last pixel of the current one has been emitted.
// Reset: rst (synchronous) clears the sequencer, counter, DC-only flag and out_valid.
module dequant_idct4x4_reconstruct_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dit_pkg::CoefW-1:0]    coefficient,
  input  logic signed [dit_pkg::CoefW-1:0]    factor,
  input  logic        [dit_pkg::PixW-1:0]     predicted_pixel,
  input  logic signed [dit_pkg::CoefW-1:0]    second_order_dc,
  input  logic                                use_second_order_dc,
  input  logic        [dit_pkg::CountW-1:0]   coefficient_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [dit_pkg::PixW-1:0]     pixel,
  output logic        [dit_pkg::IdxW-1:0]     pixel_index,
  output logic                                last_pixel
);
  import dit_pkg::*;

  state_t state, state_next;
  logic [IdxW-1:0] cnt, cnt_next;
  logic            dc_only;
  logic            emit_load;
  logic            in_fire;

  // coefficient / column-pass / residual store, shifted so reads sit at fixed taps
  logic signed [CoefW-1:0] coef [BlkN];
  logic        [PixW-1:0]  pred [BlkN];
  logic signed [CoefW-1:0] dc;

  logic signed [2*CoefW-1:0] dq_prod;
  logic signed [CoefW-1:0]   dq_val;

  logic signed [CoefW-1:0] tap0, tap1, tap2, tap3;
  logic signed [ProdW-1:0] p1s, p1c, p3s, p3c;
  logic signed [MulW-1:0]  m1s, m1c, m3s, m3c;
  logic signed [AccW-1:0]  bf_a, bf_b, bf_c, bf_d;
  logic signed [AccW-1:0]  o0, o1, o2, o3;
  logic signed [AccW-1:0]  r0, r1, r2, r3;

  logic signed [CoefW:0]   dc_sum;
  logic signed [CoefW:0]   dc_add;
  logic signed [CoefW-1:0] res;
  logic signed [CoefW+1:0] recon;
  logic        [PixW-1:0]  recon_clamped;

  assign in_fire = in_valid && in_ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_next = cnt + 4'd1;
          if (cnt == 4'(BlkN - 1)) begin
            state_next = dc_only ? ST_EMIT : ST_COL_MUL;
          end
        end
      end
      ST_COL_MUL: state_next = ST_COL_SUM;
      ST_COL_SUM: begin
        cnt_next = cnt + 4'd1;
        if (cnt[1:0] == 2'd3) begin
          cnt_next   = '0;
          state_next = ST_ROW_MUL;
        end else begin
          state_next = ST_COL_MUL;
        end
      end
      ST_ROW_MUL: state_next = ST_ROW_SUM;
      ST_ROW_SUM: begin
        cnt_next = cnt + 4'd1;
        if (cnt[1:0] == 2'd3) begin
          cnt_next   = '0;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ROW_MUL;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_load = 1'b1;
          cnt_next  = cnt + 4'd1;
          if (cnt == 4'(BlkN - 1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      dc_only   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (in_fire && cnt == '0) begin
        dc_only <= (coefficient_count <= 5'd1);
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- dequant on entry ----------------
  assign dq_prod = coefficient * factor;
  // external DC replaces element zero on both paths
  assign dq_val  = (cnt == '0 && use_second_order_dc) ? second_order_dc : dq_prod[CoefW-1:0];

  // ---------------- shared butterfly ----------------
  // column pass reads column 0 of a store that rotates by one per pass,
  // row pass reads row 0 of a store that rotates by four per pass
  always_comb begin
    tap0 = coef[0];
    if (state == ST_COL_MUL || state == ST_COL_SUM) begin
      tap1 = coef[4];
      tap2 = coef[8];
      tap3 = coef[12];
    end else begin
      tap1 = coef[1];
      tap2 = coef[2];
      tap3 = coef[3];
    end
  end

  assign p1s = tap1 * SIN_TERM;
  assign p1c = tap1 * COS_TERM;
  assign p3s = tap3 * SIN_TERM;
  assign p3c = tap3 * COS_TERM;

  assign bf_a = AccW'(tap0) + AccW'(tap2);
  assign bf_b = AccW'(tap0) - AccW'(tap2);
  assign bf_c = AccW'(m1s) - (AccW'(tap3) + AccW'(m3c));
  assign bf_d = (AccW'(tap1) + AccW'(m1c)) + AccW'(m3s);

  assign o0 = bf_a + bf_d;
  assign o1 = bf_b + bf_c;
  assign o2 = bf_b - bf_c;
  assign o3 = bf_a - bf_d;

  assign r0 = o0 + 20'sd4;
  assign r1 = o1 + 20'sd4;
  assign r2 = o2 + 20'sd4;
  assign r3 = o3 + 20'sd4;

  // ---------------- reconstruct ----------------
  assign dc_sum = 17'(dc) + 17'sd4;
  assign dc_add = dc_sum >>> 3;
  assign res    = dc_only ? dc_add[CoefW-1:0] : coef[0];
  assign recon  = 18'(res) + $signed({10'b0, pred[0]});

  always_comb begin
    if (recon[CoefW+1]) begin
      recon_clamped = '0;
    end else if (recon[CoefW:PixW] != '0) begin
      recon_clamped = 8'd255;
    end else begin
      recon_clamped = recon[PixW-1:0];
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        if (in_fire) begin
          for (int k = 0; k < BlkN - 1; k++) begin
            coef[k] <= coef[k+1];
            pred[k] <= pred[k+1];
          end
          coef[BlkN-1] <= dq_val;
          pred[BlkN-1] <= predicted_pixel;
          if (cnt == '0) begin
            dc <= dq_val;
          end
        end
      end
      ST_COL_MUL, ST_ROW_MUL: begin
        m1s <= p1s[ProdW-1:16];
        m1c <= p1c[ProdW-1:16];
        m3s <= p3s[ProdW-1:16];
        m3c <= p3c[ProdW-1:16];
      end
      ST_COL_SUM: begin
        // last slot of each row takes the new column result
        for (int k = 0; k < BlkN - 1; k++) begin
          if (k[1:0] != 2'd3) begin
            coef[k] <= coef[k+1];
          end
        end
        coef[3]  <= o0[CoefW-1:0];
        coef[7]  <= o1[CoefW-1:0];
        coef[11] <= o2[CoefW-1:0];
        coef[15] <= o3[CoefW-1:0];
      end
      ST_ROW_SUM: begin
        for (int k = 0; k < BlkN - 4; k++) begin
          coef[k] <= coef[k+4];
        end
        coef[12] <= r0[CoefW+2:3];
        coef[13] <= r1[CoefW+2:3];
        coef[14] <= r2[CoefW+2:3];
        coef[15] <= r3[CoefW+2:3];
      end
      ST_EMIT: begin
        if (emit_load) begin
          pixel       <= recon_clamped;
          pixel_index <= cnt;
          last_pixel  <= (cnt == 4'(BlkN - 1));
          for (int k = 0; k < BlkN - 1; k++) begin
            coef[k] <= coef[k+1];
            pred[k] <= pred[k+1];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/dit_checker.sv
// Port-level checker for the reconstruct core, bound to the top level.
module dit_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel,
  input logic [3:0] pixel_index,
  input logic       last_pixel
);

  // last flag marks the final raster position
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_pixel == (pixel_index == 4'd15)))
    else $error("last_pixel does not match pixel_index 15");

  // pixels of a block stream back to back in raster order
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_pixel) |=>
      (out_valid && pixel_index == $past(pixel_index) + 4'd1))
    else $error("pixel index sequence broken");

  // no new block is taken while the current one is still being emitted
  a_no_load_mid_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_pixel) |-> !in_ready)
    else $error("input taken while block output in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(pixel) && $stable(pixel_index) && $stable(last_pixel)))
    else $error("stalled output item changed");

endmodule

bind dequant_idct4x4_reconstruct_core dit_checker u_dit_checker (.*);

### verif/tb_dequant_idct4x4_reconstruct_core.sv
// Testbench for the 4x4 dequant / inverse DCT / reconstruct core: directed and random blocks, predicted pixels.
`timescale 1ns / 1ps

module tb_dequant_idct4x4_reconstruct_core;

  localparam int unsigned DcOnlyMaxCount = 1;
  localparam int unsigned IdlePct        = 18;
  localparam int unsigned RandomBlocks   = 21;
  localparam int unsigned DrainBlock     = 10;
  localparam int unsigned SettleCycles   = 100;

  typedef struct {
    logic signed [dit_pkg::CoefW-1:0]  coefficient;
    logic signed [dit_pkg::CoefW-1:0]  factor;
    logic        [dit_pkg::PixW-1:0]   predicted_pixel;
    logic signed [dit_pkg::CoefW-1:0]  second_order_dc;
    logic                              use_second_order_dc;
    logic        [dit_pkg::CountW-1:0] coefficient_count;
    bit                                wait_drain;
  } coef_item_t;

  typedef struct {
    logic [dit_pkg::PixW-1:0] pixel;
    logic [dit_pkg::IdxW-1:0] pixel_index;
    logic                     last_pixel;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [dit_pkg::CoefW-1:0]  coefficient = '0;
  logic signed [dit_pkg::CoefW-1:0]  factor = '0;
  logic        [dit_pkg::PixW-1:0]   predicted_pixel = '0;
  logic signed [dit_pkg::CoefW-1:0]  second_order_dc = '0;
  logic                              use_second_order_dc = 1'b0;
  logic        [dit_pkg::CountW-1:0] coefficient_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dit_pkg::PixW-1:0] pixel;
  logic [dit_pkg::IdxW-1:0] pixel_index;
  logic last_pixel;

  coef_item_t pending_items[$];
  coef_item_t cur_item;
  pixel_t     expected_pixels[$];
  pixel_t     want;
  int         mismatch_cnt = 0;
  int         sent_cnt = 0;
  int         got_cnt = 0;
  bit         send_now;

  // predictor state
  longint                     dequant_store[16];
  logic [dit_pkg::PixW-1:0]   pred_store[16];
  logic [3:0]                 elem_ctr = '0;
  longint                     held_dc = 0;
  bit                         held_flag = 1'b0;
  logic [dit_pkg::CountW-1:0] held_cnt = '0;

  dequant_idct4x4_reconstruct_core DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .coefficient         (coefficient),
    .factor              (factor),
    .predicted_pixel     (predicted_pixel),
    .second_order_dc     (second_order_dc),
    .use_second_order_dc (use_second_order_dc),
    .coefficient_count   (coefficient_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .pixel               (pixel),
    .pixel_index         (pixel_index),
    .last_pixel          (last_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint wrap16(input longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  function automatic longint const_mul(input longint x, input longint w);
    return (x * w) >>> 16;
  endfunction

  function automatic void butterfly(input longint i0, input longint i1, input longint i2,
                                    input longint i3, output longint o0, output longint o1,
                                    output longint o2, output longint o3);
    longint a, b, c, d, cs, sn;
    cs = longint'(dit_pkg::COS_TERM);
    sn = longint'(dit_pkg::SIN_TERM);
    a = i0 + i2;
    b = i0 - i2;
    c = const_mul(i1, sn) - (i3 + const_mul(i3, cs));
    d = (i1 + const_mul(i1, cs)) + const_mul(i3, sn);
    o0 = a + d;
    o1 = b + c;
    o2 = b - c;
    o3 = a - d;
  endfunction

  // Absorb one accepted item; after element 15, queue the 16 reconstructed pixels.
  function automatic void load_element(input coef_item_t it);
    int     e;
    longint blk[16];
    longint col[16];
    longint res[16];
    longint o0, o1, o2, o3, dc, sum;
    pixel_t px;
    e = int'(elem_ctr);
    dequant_store[e] = wrap16(longint'(it.coefficient) * longint'(it.factor));
    pred_store[e] = it.predicted_pixel;
    if (e == 0) begin
      held_dc   = longint'(it.second_order_dc);
      held_flag = it.use_second_order_dc;
      held_cnt  = it.coefficient_count;
    end
    elem_ctr = elem_ctr + 4'd1;
    if (e != 15) return;

    if (held_cnt <= DcOnlyMaxCount) begin
      dc = held_flag ? held_dc : dequant_store[0];
      for (int i = 0; i < 16; i++) res[i] = (dc + 4) >>> 3;
    end else begin
      for (int i = 0; i < 16; i++) blk[i] = dequant_store[i];
      if (held_flag) blk[0] = held_dc;
      for (int i = 0; i < 4; i++) begin
        butterfly(blk[i], blk[4+i], blk[8+i], blk[12+i], o0, o1, o2, o3);
        col[i]    = wrap16(o0);
        col[4+i]  = wrap16(o1);
        col[8+i]  = wrap16(o2);
        col[12+i] = wrap16(o3);
      end
      for (int i = 0; i < 4; i++) begin
        butterfly(col[4*i], col[4*i+1], col[4*i+2], col[4*i+3], o0, o1, o2, o3);
        res[4*i]   = wrap16((o0 + 4) >>> 3);
        res[4*i+1] = wrap16((o1 + 4) >>> 3);
        res[4*i+2] = wrap16((o2 + 4) >>> 3);
        res[4*i+3] = wrap16((o3 + 4) >>> 3);
      end
    end

    for (int i = 0; i < 16; i++) begin
      sum = res[i] + longint'(pred_store[i]);
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      px.pixel       = sum[7:0];
      px.pixel_index = i[3:0];
      px.last_pixel  = (i == 15);
      expected_pixels.push_back(px);
    end
  endfunction

  // style 0: full-range values, 1: small realistic values, 2: sparse mix
  task automatic add_block(input logic [4:0] cnt, input bit flag, input int style,
                           input bit drain);
    coef_item_t it;
    for (int i = 0; i < 16; i++) begin
      it.predicted_pixel = 8'($urandom_range(255));
      if (style == 1 || (style == 2 && $urandom_range(3) != 0)) begin
        it.coefficient = (style == 2 && i > 3) ? 16'sd0 : 16'($urandom_range(200) - 100);
        it.factor      = 16'($urandom_range(160, 1));
      end else begin
        it.coefficient = 16'($urandom());
        it.factor      = 16'($urandom());
      end
      if (i == 0) begin
        it.second_order_dc     = (style == 1) ? 16'($urandom_range(2000) - 1000)
                                              : 16'($urandom());
        it.use_second_order_dc = flag;
        it.coefficient_count   = cnt;
        it.wait_drain          = drain;
      end else begin
        // ignored at nonzero elements
        it.second_order_dc     = 16'($urandom());
        it.use_second_order_dc = 1'($urandom_range(1));
        it.coefficient_count   = 5'($urandom_range(31));
        it.wait_drain          = 1'b0;
      end
      pending_items.push_back(it);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        load_element(cur_item);
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        send_now = pending_items.size() != 0;
        if (send_now && pending_items[0].wait_drain && expected_pixels.size() != 0)
          send_now = 1'b0;
        if (send_now && !(sent_cnt >= 176 && sent_cnt < 272) &&
            $urandom_range(99) < IdlePct)
          send_now = 1'b0;
        if (send_now) begin
          cur_item = pending_items.pop_front();
          coefficient         <= cur_item.coefficient;
          factor              <= cur_item.factor;
          predicted_pixel     <= cur_item.predicted_pixel;
          second_order_dc     <= cur_item.second_order_dc;
          use_second_order_dc <= cur_item.use_second_order_dc;
          coefficient_count   <= cur_item.coefficient_count;
        end
        in_valid <= send_now;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_cnt++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel item: pixel %0d index %0d last %0d",
                 pixel, pixel_index, last_pixel);
          mismatch_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want.pixel) begin
            $error("pixel: expected %0d, actual %0d", want.pixel, pixel);
            mismatch_cnt++;
          end
          if (pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d", want.pixel_index, pixel_index);
            mismatch_cnt++;
          end
          if (last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, actual %0d", want.last_pixel, last_pixel);
            mismatch_cnt++;
          end
        end
      end
      if (got_cnt >= 96 && got_cnt < 192) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin
    coef_item_t it;
    int r;
    logic [4:0] cnt;

    // DC-only from coefficient 0: negative dc rounds to nearest, clamps at zero;
    // side fields at nonzero elements carry values that must be ignored
    for (int i = 0; i < 16; i++) begin
      it.coefficient         = (i == 0) ? -16'sd3 : ((i % 2) ? 16'sh7fff : 16'sh8000);
      it.factor              = (i == 0) ? 16'sd3 : 16'sh8000;
      it.predicted_pixel     = (i % 2) ? 8'd255 : 8'd0;
      it.second_order_dc     = (i == 0) ? 16'sh7fff : 16'sh8000;
      it.use_second_order_dc = (i != 0);
      it.coefficient_count   = (i == 0) ? 5'd0 : 5'd31;
      it.wait_drain          = 1'b0;
      pending_items.push_back(it);
    end
    // full path, count above 16, external DC at the negative extreme, extreme coefficients
    for (int i = 0; i < 16; i++) begin
      it.coefficient         = (i % 2) ? 16'sh8000 : 16'sh7fff;
      it.factor              = (i % 3) ? 16'sh7fff : 16'sh8000;
      it.predicted_pixel     = (i % 2) ? 8'd0 : 8'd255;
      it.second_order_dc     = (i == 0) ? 16'sh8000 : 16'sh7fff;
      it.use_second_order_dc = (i == 0);
      it.coefficient_count   = (i == 0) ? 5'd31 : 5'd0;
      it.wait_drain          = 1'b0;
      pending_items.push_back(it);
    end

    for (int b = 0; b < RandomBlocks; b++) begin
      r = int'($urandom_range(99));
      if (r < 25) cnt = 5'($urandom_range(1));
      else if (r < 85) cnt = 5'($urandom_range(16, 2));
      else cnt = 5'($urandom_range(31, 17));
      add_block(cnt, 1'($urandom_range(1)), int'($urandom_range(2)), b == DrainBlock);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
